// ===== hw/rtl/olad_pkg.sv =====
`timescale 1ns / 1ps

package olad_pkg;

	// Capacity of the list and the widths that follow from it.
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LIST   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_LIST_RD,
		S_LIST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    cap_value;
		logic    idx_clr;
		logic    idx_inc;
		logic    rd_en;
		logic    rd_next;
		logic    wr_app;
		logic    wr_shift;
		logic    cnt_dec;
		logic    out_load;
		status_t out_status;
		logic    out_entry_valid;
		logic    out_last;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic full;
		logic match;
		logic idx_last;
		logic idx_penult;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hw/rtl/ordered_list_append_delete.sv =====
`timescale 1ns / 1ps
// An append, or any request on an empty list, goes to the response state, which loads the
// result register once it is free. A delete reads and compares one entry at a time from the
// head until a match or the last entry, then shifts each later entry down one place (a read,
// then a write); a listing loads each entry it reads into the result register once it is free.
// Throughput: one transaction at a time; the next is accepted once the current walk is done.
// Reset: asynchronous, active low; the list is emptied and the result valid flag cleared.
module ordered_list_append_delete (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] entry,
	output logic               entry_valid,
	output logic               last
);
	import olad_pkg::*;

	// The controller sequences each transaction over the list store; the datapath
	// holds the store, the entry count, the walk index and the result register.
	dp_cmd_t cmd;
	dp_sts_t sts;
	status_t status_w;

	olad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The result register sits in the datapath, so a finished result can wait
	// for the consumer while the controller returns to idle.
	olad_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status_w),
		.entry       (entry),
		.entry_valid (entry_valid),
		.last        (last)
	);

	assign status = 2'(status_w);

endmodule

// ===== hw/rtl/olad_datapath.sv =====
`timescale 1ns / 1ps

module olad_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  olad_pkg::dp_cmd_t             cmd,
	output olad_pkg::dp_sts_t             sts,
	input  logic signed [31:0]            value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output olad_pkg::status_t             status,
	output logic signed [31:0]            entry,
	output logic                          entry_valid,
	output logic                          last
);
	import olad_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [DATA_W-1:0] value_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] entry_q;
	logic              entry_valid_q;
	logic              last_q;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [IDX_W-1:0]  rd_addr;
	logic [CNT_W-1:0]  idx_wide;

	assign idx_wide = CNT_W'(idx_q);
	assign wr_en    = cmd.wr_app | cmd.wr_shift;
	assign wr_addr  = cmd.wr_app ? count_q[IDX_W-1:0] : idx_q;
	assign wr_data  = cmd.wr_app ? DATA_W'(value) : rd_data_q;
	assign rd_addr  = cmd.rd_next ? IDX_W'(idx_wide + CNT_W'(1)) : idx_q;

	// Single-port-style store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
		if (cmd.cap_value) begin
			value_q <= DATA_W'(value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.wr_app) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Output register decouples the result side from the list walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q      <= cmd.out_status;
			entry_q       <= cmd.out_entry_valid ? rd_data_q : '0;
			entry_valid_q <= cmd.out_entry_valid;
			last_q        <= cmd.out_last;
		end
	end

	assign sts.count_zero = (count_q == '0);
	assign sts.full       = (count_q == CNT_W'(DEPTH));
	assign sts.match      = (rd_data_q == value_q);
	assign sts.idx_last   = ((idx_wide + CNT_W'(1)) == count_q);
	assign sts.idx_penult = ((idx_wide + CNT_W'(2)) == count_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry       = entry_q;
	assign entry_valid = entry_valid_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds capacity");
	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_app |-> !sts.full)
		else $error("append written into a full list");
	a_no_dec_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> !sts.count_zero)
		else $error("entry count decremented below zero");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");
`endif

endmodule

// ===== hw/rtl/olad_ctrl.sv =====
`timescale 1ns / 1ps

module olad_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  olad_pkg::dp_sts_t sts,
	output olad_pkg::dp_cmd_t cmd
);
	import olad_pkg::*;

	state_t  state_q, state_d;
	status_t resp_q, resp_d;
	logic    accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			resp_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		resp_d   = resp_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.out_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					case (action)
						ACT_APPEND: begin
							if (sts.full) begin
								resp_d = ST_FULL;
							end else begin
								cmd.wr_app = 1'b1;
								resp_d     = ST_OK;
							end
							state_d = S_RESP;
						end
						ACT_DELETE: begin
							if (sts.count_zero) begin
								resp_d  = ST_EMPTY;
								state_d = S_RESP;
							end else begin
								cmd.cap_value = 1'b1;
								cmd.idx_clr   = 1'b1;
								state_d       = S_SRCH_RD;
							end
						end
						ACT_LIST: begin
							if (sts.count_zero) begin
								resp_d  = ST_EMPTY;
								state_d = S_RESP;
							end else begin
								cmd.idx_clr = 1'b1;
								state_d     = S_LIST_RD;
							end
						end
						default: begin
							// Unused code: dropped with no result.
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = resp_q;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_SRCH_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (sts.match) begin
					if (sts.idx_last) begin
						cmd.cnt_dec = 1'b1;
						resp_d      = ST_OK;
						state_d     = S_RESP;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end else if (sts.idx_last) begin
					resp_d  = ST_NOT_FOUND;
					state_d = S_RESP;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SRCH_RD;
				end
			end
			S_SHIFT_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_next = 1'b1;
				state_d     = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				if (sts.idx_penult) begin
					cmd.cnt_dec = 1'b1;
					resp_d      = ST_OK;
					state_d     = S_RESP;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_LIST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LIST_EMIT;
			end
			S_LIST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load        = 1'b1;
					cmd.out_status      = ST_OK;
					cmd.out_entry_valid = 1'b1;
					cmd.out_last        = sts.idx_last;
					if (sts.idx_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_LIST_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
